### rtl/ean_pkg.sv
// Shared types, constants and tables of the eccentric anomaly solver.
package ean_pkg;

  localparam int ANGLE_WIDTH     = 32;
  localparam int ANGLE_FRAC_BITS = 28;
  localparam int ITER_W          = 11;
  localparam int TOL_W           = 16;
  localparam int ECC_W           = 32;
  localparam int Q30_SHIFT       = 30 - ANGLE_FRAC_BITS;
  localparam int ES_SHIFT        = 62 - ANGLE_FRAC_BITS;
  localparam int CORDIC_STEPS    = 30;
  localparam int NUM_W           = 35;
  localparam int QUOT_W          = 34;
  localparam int DIV_PRESHIFT    = 62 - QUOT_W;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [33:0] cq_t;
  typedef logic signed [31:0] trig_t;

  typedef enum logic [1:0] {
    REG_ECC   = 2'd0,
    REG_MAXIT = 2'd1,
    REG_TOL   = 2'd2
  } reg_idx_t;

  localparam logic [ECC_W-1:0]  ECC_RESET   = '0;
  localparam logic [ITER_W-1:0] MAXIT_RESET = 11'd2000;
  localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd1;

  // Pi and two pi in the angle format, pi rounded to the fraction bits.
  localparam cq_t PI_ANG      = 34'sd843314857;
  localparam cq_t TWO_PI_ANG  = 34'sd1686629714;
  localparam cq_t PI_Q30      = 34'sd3373259426;
  localparam cq_t HALF_PI_Q30 = 34'sd1686629713;
  localparam cq_t GAIN_Q30    = 34'sd652032874;
  localparam cq_t ONE_Q30     = 34'sd1073741824;

  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
  };

endpackage

### rtl/ean_if.sv
// Valid/ready channel interfaces for mean anomaly input and solution output.
interface ean_in_if import ean_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t mean_anomaly;
  modport source (output valid, output mean_anomaly, input ready);
  modport sink (input valid, input mean_anomaly, output ready);
endinterface

interface ean_out_if import ean_pkg::*; ();
  logic              valid;
  logic              ready;
  angle_t            eccentric_anomaly;
  logic              converged;
  logic [ITER_W-1:0] iterations_used;
  modport source (output valid, output eccentric_anomaly, output converged,
                  output iterations_used, input ready);
  modport sink (input valid, input eccentric_anomaly, input converged,
                input iterations_used, output ready);
endinterface

### rtl/ean_cordic.sv
// Iterative rotation CORDIC giving Q2.30 sine and cosine of a Q4.28 angle.
module ean_cordic import ean_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  angle_t angle,
  output trig_t  sin_out,
  output trig_t  cos_out,
  output logic   done
);

  typedef enum logic [1:0] {C_IDLE, C_FOLD, C_ROT, C_OUT} cstate_t;

  cstate_t     state;
  cq_t         x, y, z;
  logic        flip;
  logic [4:0]  idx;

  cq_t a_ext, r1, r2, q, qf, dx, dy, atan_v, xc, yc;
  logic flip_next;

  always_comb begin
    a_ext = {{2{angle[ANGLE_WIDTH-1]}}, angle};
    if (a_ext >= TWO_PI_ANG) r1 = a_ext - TWO_PI_ANG;
    else if (a_ext <= -TWO_PI_ANG) r1 = a_ext + TWO_PI_ANG;
    else r1 = a_ext;

    if (z > PI_ANG) r2 = z - TWO_PI_ANG;
    else if (z < -PI_ANG) r2 = z + TWO_PI_ANG;
    else r2 = z;
    q = r2 <<< Q30_SHIFT;
    flip_next = 1'b1;
    if (q > HALF_PI_Q30) qf = q - PI_Q30;
    else if (q < -HALF_PI_Q30) qf = q + PI_Q30;
    else begin
      qf = q;
      flip_next = 1'b0;
    end

    dx = y >>> idx;
    dy = x >>> idx;
    atan_v = {4'b0, ATAN_Q30[idx]};

    if (x > ONE_Q30) xc = ONE_Q30;
    else if (x < -ONE_Q30) xc = -ONE_Q30;
    else xc = x;
    if (y > ONE_Q30) yc = ONE_Q30;
    else if (y < -ONE_Q30) yc = -ONE_Q30;
    else yc = y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            z     <= r1;
            state <= C_FOLD;
          end
        end
        C_FOLD: begin
          z     <= qf;
          flip  <= flip_next;
          x     <= GAIN_Q30;
          y     <= '0;
          idx   <= '0;
          state <= C_ROT;
        end
        C_ROT: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - atan_v;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + atan_v;
          end
          idx <= idx + 5'd1;
          if (idx == 5'(CORDIC_STEPS - 1)) state <= C_OUT;
        end
        C_OUT: begin
          sin_out <= flip ? trig_t'(-yc) : trig_t'(yc);
          cos_out <= flip ? trig_t'(-xc) : trig_t'(xc);
          done    <= 1'b1;
          state   <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### rtl/ean_divider.sv
// Bit-serial restoring divider for the Newton step, saturating its quotient.
module ean_divider import ean_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [63:0]       den,
  output logic [QUOT_W-1:0] quot,
  output logic              done
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t     state;
  logic [63:0] rem, dreg;
  logic [5:0]  cnt;
  logic [63:0] r0;
  logic [64:0] r2;
  logic        fits;

  always_comb begin
    r0   = 64'(num) << DIV_PRESHIFT;
    r2   = {rem, 1'b0};
    fits = r2 >= {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            if (r0 >= den) begin
              // The quotient would not fit: any value this large saturates the quotient to all ones.
              quot <= '1;
              done <= 1'b1;
            end else begin
              rem   <= r0;
              dreg  <= den;
              quot  <= '0;
              cnt   <= '0;
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem  <= fits ? 64'(r2 - {1'b0, dreg}) : r2[63:0];
          quot <= {quot[QUOT_W-2:0], fits};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(QUOT_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

### rtl/eccentric_anomaly_newton_solver_top.sv
// Top level of the Kepler's equation Newton solver with its register port.
//
// The block solves E - e*sin(E) = M for the eccentric anomaly E. A mean
// anomaly M arrives as one transaction on the in_ch channel; the solution,
// a convergence flag and the number of Newton steps leave as one
// transaction on out_ch. Angles are signed Q4.28 radians.
// The APB port holds three registers: eccentricity at address 0,
// max_iterations at 4 and step_tolerance at 8. Write them only while idle.
// Each Newton step runs the shared CORDIC, then the shared multiplier twice,
// forms the residual, runs the bit-serial divider (cut short when the
// quotient saturates) and ends with the update.
// The sequencer handles one item at a time: in_ch.ready is high only while
// no item is being solved.
// A finished result sits in the output register until taken; the solver
// accepts the next item while it waits, and stalls only when a second
// result is ready before the first has left.
// Synchronous reset clears the sequencer and loads the register defaults
// (eccentricity 0, max_iterations 2000, step_tolerance 1).
module eccentric_anomaly_newton_solver_top import ean_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ean_in_if.sink      in_ch,
  ean_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_TRIG, S_MUL_S, S_MUL_C, S_RESID, S_DIV, S_UPDATE, S_FINISH
  } state_t;

  state_t            state;
  logic [ECC_W-1:0]  eccentricity;
  logic [ITER_W-1:0] max_iterations;
  logic [TOL_W-1:0]  step_tolerance;
  angle_t            m_reg, estimate;
  logic [ITER_W-1:0] step_count;
  logic              conv;
  trig_t             sn, cs;
  logic [62:0]       prod;
  logic signed [35:0] es, g;
  logic [63:0]       den;
  logic              cordic_start, div_start;

  trig_t             sin_w, cos_w;
  logic              cordic_done, div_done;
  logic [QUOT_W-1:0] quot;

  logic              out_valid;
  angle_t            out_e;
  logic              out_conv;
  logic [ITER_W-1:0] out_iter;

  // Register port: writes complete in the access phase; reads are combinational.
  reg_idx_t reg_idx;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_ECC:   prdata = eccentricity;
      REG_MAXIT: prdata = 32'(max_iterations);
      REG_TOL:   prdata = 32'(step_tolerance);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eccentricity   <= ECC_RESET;
      max_iterations <= MAXIT_RESET;
      step_tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_ECC:   eccentricity   <= pwdata;
        REG_MAXIT: max_iterations <= pwdata[ITER_W-1:0];
        REG_TOL:   step_tolerance <= pwdata[TOL_W-1:0];
        default:   ;
      endcase
    end
  end

  ean_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (estimate),
    .sin_out (sin_w),
    .cos_out (cos_w),
    .done    (cordic_done)
  );

  // The divider takes the residual magnitude and the denominator 1 - e*cos E.
  logic [NUM_W-1:0] g_mag;
  assign g_mag = g[35] ? NUM_W'(-g) : NUM_W'(g);

  ean_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (g_mag),
    .den   (den),
    .quot  (quot),
    .done  (div_done)
  );

  // One shared multiplier: e*|sin E| first, then e*|cos E|.
  logic [30:0] mul_b, sn_mag, cs_mag;
  assign sn_mag = sn[31] ? 31'(-sn) : 31'(sn);
  assign cs_mag = cs[31] ? 31'(-cs) : 31'(cs);
  assign mul_b  = (state == S_MUL_S) ? sn_mag : cs_mag;

  logic signed [35:0] es_mag;
  logic [63:0]        den_w;
  logic signed [35:0] g_w;
  assign es_mag = 36'(prod >> ES_SHIFT);
  assign den_w  = cs[31] ? (64'(1) << 62) + 64'(prod) : (64'(1) << 62) - 64'(prod);
  assign g_w    = 36'(estimate) - es - 36'(m_reg);

  // Estimate update: subtract the signed step, clamp, and measure the change.
  logic signed [37:0] step_w, nxt_w;
  angle_t             nxt;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic               small_step;
  localparam logic signed [37:0] ANG_MAX = 38'((64'(1) << (ANGLE_WIDTH - 1)) - 1);
  localparam logic signed [37:0] ANG_MIN = -ANG_MAX - 38'sd1;

  always_comb begin
    step_w = g[35] ? -38'(quot) : 38'(quot);
    nxt_w  = 38'(estimate) - step_w;
    if (nxt_w > ANG_MAX) nxt = angle_t'(ANG_MAX);
    else if (nxt_w < ANG_MIN) nxt = angle_t'(ANG_MIN);
    else nxt = angle_t'(nxt_w);
    diff       = 33'(nxt) - 33'(estimate);
    diff_mag   = diff[32] ? 33'(-diff) : 33'(diff);
    small_step = diff_mag <= 33'(step_tolerance);
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      cordic_start <= 1'b0;
      div_start    <= 1'b0;
      estimate     <= '0;
      step_count   <= '0;
    end else begin
      cordic_start <= 1'b0;
      div_start    <= 1'b0;
      // A result is loaded when the output register is empty or being taken.
      if (state == S_FINISH && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            m_reg      <= in_ch.mean_anomaly;
            estimate   <= in_ch.mean_anomaly;
            step_count <= '0;
            conv       <= 1'b0;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (max_iterations == '0) state <= S_FINISH;
          else begin
            cordic_start <= 1'b1;
            state        <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (cordic_done) begin
            sn    <= sin_w;
            cs    <= cos_w;
            state <= S_MUL_S;
          end
        end
        S_MUL_S: begin
          prod  <= 63'(eccentricity) * 63'(mul_b);
          state <= S_MUL_C;
        end
        S_MUL_C: begin
          es    <= sn[31] ? -es_mag : es_mag;
          prod  <= 63'(eccentricity) * 63'(mul_b);
          state <= S_RESID;
        end
        S_RESID: begin
          g         <= g_w;
          den       <= den_w;
          div_start <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_UPDATE;
        end
        S_UPDATE: begin
          estimate   <= nxt;
          step_count <= step_count + 11'd1;
          if (small_step) begin
            conv  <= 1'b1;
            state <= S_FINISH;
          end else if (step_count + 11'd1 >= max_iterations) begin
            state <= S_FINISH;
          end else begin
            cordic_start <= 1'b1;
            state        <= S_TRIG;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_e    <= estimate;
            out_conv <= conv;
            out_iter <= step_count;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready              = (state == S_IDLE);
  assign out_ch.valid             = out_valid;
  assign out_ch.eccentric_anomaly = out_e;
  assign out_ch.converged         = out_conv;
  assign out_ch.iterations_used   = out_iter;

  // A converged result has run at least one Newton step.
  a_conv_steps: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.converged |-> out_ch.iterations_used != '0)
    else $error("converged result with zero steps");

  // The step counter never runs past the limit while an item is solved.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> step_count <= max_iterations)
    else $error("step count beyond limit");

  // Accepting an item closes the input until that item is done.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while busy");

  // The divider is only started from the residual state, after the CORDIC has finished.
  a_div_after_trig: assert property (@(posedge clk) disable iff (rst)
    div_start |-> $past(state == S_RESID))
    else $error("divider started out of sequence");

endmodule

### test/tb_eccentric_anomaly_newton_solver_top.sv
// Testbench for the Kepler's equation Newton solver: directed table, then random items.
`timescale 1ns / 1ps

module tb_eccentric_anomaly_newton_solver_top;
  import ean_pkg::*;

  // The longest legal item runs 2047 Newton steps, so a quiet stretch longer
  // than this limit means the block has hung.
  localparam int QUIET_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    angle_t                 anomaly;
    logic                   converged;
    logic [ITER_W-1:0]      iterations;
  } solution_t;

  typedef enum logic {ROW_WRITE, ROW_SOLVE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    reg_sel;
    logic [31:0] reg_value;
    angle_t      mean;
    logic        typed;
    solution_t   want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ean_in_if in_ch ();
  ean_out_if out_ch ();

  eccentric_anomaly_newton_solver_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the register file, used by the solver model.
  logic [ECC_W-1:0] ecc_shadow = ECC_RESET;
  logic [ITER_W-1:0] maxit_shadow = MAXIT_RESET;
  logic [TOL_W-1:0] tol_shadow = TOL_RESET;

  solution_t pending_solutions[$];
  int src_idle = 0;
  int snk_idle = 0;
  int errors = 0;
  int solved = 0;
  int checked = 0;
  int quiet = 0;
  int unconverged = 0;

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Rotation CORDIC with range reduction, matching the block's Q2.30 trig.
  function automatic void trig_q30(input longint ang, output longint sn, output longint cs);
    longint half_turn, full_turn, r, z, x, y, dx, dy;
    longint unsigned m;
    logic flip;
    half_turn = longint'(PI_ANG);
    full_turn = 2 * half_turn;
    flip = 1'b0;
    r = ang % full_turn;
    if (r > half_turn) r -= full_turn;
    if (r < -half_turn) r += full_turn;
    m = magnitude(r) << Q30_SHIFT;
    z = r < 0 ? -longint'(m) : longint'(m);
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      flip = 1'b1;
    end
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'({34'd0, ATAN_Q30[i]});
      end else begin
        x += dx; y -= dy; z += longint'({34'd0, ATAN_Q30[i]});
      end
    end
    if (x > longint'(ONE_Q30)) x = longint'(ONE_Q30);
    if (x < -longint'(ONE_Q30)) x = -longint'(ONE_Q30);
    if (y > longint'(ONE_Q30)) y = longint'(ONE_Q30);
    if (y < -longint'(ONE_Q30)) y = -longint'(ONE_Q30);
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // One Newton update of the estimate, saturated to the angle range.
  function automatic longint newton_update(input longint est, input longint mean);
    longint sn, cs, es, g, stp;
    longint unsigned pm, den, q;
    logic [127:0] num, quo;
    logic signed [65:0] wide_est, wide_step, nxt;
    trig_q30(est, sn, cs);
    pm = ({32'd0, ecc_shadow} * magnitude(sn)) >> ES_SHIFT;
    es = sn < 0 ? -longint'(pm) : longint'(pm);
    pm = {32'd0, ecc_shadow} * magnitude(cs);
    den = cs >= 0 ? (64'd1 << 62) - pm : (64'd1 << 62) + pm;
    g = est - es - mean;
    num = {64'd0, magnitude(g)} << 62;
    quo = num / {64'd0, den};
    q = quo > 128'h7FFF_FFFF_FFFF_FFFF ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];
    stp = g < 0 ? -longint'(q) : longint'(q);
    wide_est = est;
    wide_step = stp;
    nxt = wide_est - wide_step;
    if (nxt > 66'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (nxt < -66'sh8000_0000) return -64'sh8000_0000;
    return longint'(nxt);
  endfunction

  function automatic solution_t solve_kepler(input angle_t mean);
    solution_t s;
    longint est, nxt;
    longint unsigned d;
    int steps;
    logic done;
    est = mean;
    steps = 0;
    done = 1'b0;
    while (steps < maxit_shadow && !done) begin
      nxt = newton_update(est, longint'(mean));
      d = nxt >= est ? nxt - est : est - nxt;
      est = nxt;
      steps++;
      if (d <= tol_shadow) done = 1'b1;
    end
    s.anomaly = angle_t'(est);
    s.converged = done;
    s.iterations = steps[ITER_W-1:0];
    return s;
  endfunction

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ECC: ecc_shadow = value;
      REG_MAXIT: maxit_shadow = value[ITER_W-1:0];
      default: tol_shadow = value[TOL_W-1:0];
    endcase
  endtask

  // Offer one mean anomaly; returns at the edge where it was taken.
  // Valid stays high so a following transaction can go back to back.
  task automatic offer_anomaly(input angle_t mean, input logic typed, input solution_t want);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mean_anomaly <= mean;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_solutions.push_back(typed ? want : solve_kepler(mean));
    solved++;
  endtask

  // Bring the block to idle so the registers may be rewritten.
  task automatic settle;
    in_ch.valid <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result checker and random backpressure on the output side.
  always @(posedge clk) begin
    solution_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_solutions.size() == 0) begin
          $display("%0t: unexpected transaction E=%h conv=%b iters=%0d", $time,
                   out_ch.eccentric_anomaly, out_ch.converged, out_ch.iterations_used);
          errors++;
        end else begin
          want = pending_solutions.pop_front();
          checked++;
          if (!out_ch.converged) unconverged++;
          if (out_ch.eccentric_anomaly !== want.anomaly) begin
            $display("%0t: eccentric_anomaly expected %h got %h", $time, want.anomaly,
                     out_ch.eccentric_anomaly);
            errors++;
          end
          if (out_ch.converged !== want.converged) begin
            $display("%0t: converged expected %b got %b", $time, want.converged,
                     out_ch.converged);
            errors++;
          end
          if (out_ch.iterations_used !== want.iterations) begin
            $display("%0t: iterations_used expected %0d got %0d", $time, want.iterations,
                     out_ch.iterations_used);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: any transaction or register write counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic row_t write_row(input reg_idx_t idx, input logic [31:0] value);
    row_t r;
    r = '{ROW_WRITE, idx, value, '0, 1'b0, '{'0, 1'b0, '0}};
    return r;
  endfunction

  function automatic row_t solve_row(input angle_t mean, input logic typed, input logic conv,
                                     input int iters);
    row_t r;
    r = '{ROW_SOLVE, REG_ECC, '0, mean, typed, '{mean, conv, iters[ITER_W-1:0]}};
    return r;
  endfunction

  row_t plan[$];

  initial begin
    solution_t none;
    angle_t mean;
    int mode;
    int count;
    int pick;
    none = '{'0, 1'b0, '0};
    in_ch.valid <= 1'b0;
    in_ch.mean_anomaly <= '0;

    // Directed part. With reset defaults the eccentricity is zero, so every
    // mean anomaly solves to itself after a single step.
    plan.push_back(solve_row(32'sh0000_0000, 1'b1, 1'b1, 1));
    plan.push_back(solve_row(32'sh7FFF_FFFF, 1'b1, 1'b1, 1));
    plan.push_back(solve_row(32'sh8000_0000, 1'b1, 1'b1, 1));
    plan.push_back(solve_row(32'sh3243_F6A9, 1'b1, 1'b1, 1));
    // A zero iteration limit runs no step and hands M straight back.
    plan.push_back(write_row(REG_MAXIT, 32'd0));
    plan.push_back(write_row(REG_ECC, 32'hFFFF_FFFF));
    plan.push_back(solve_row(32'sh1234_5678, 1'b1, 1'b0, 0));
    plan.push_back(solve_row(32'sh8000_0000, 1'b1, 1'b0, 0));
    // Near-unit eccentricity with the full default limit, then the largest
    // limit the register holds and zero tolerance.
    plan.push_back(write_row(REG_MAXIT, 32'd2000));
    plan.push_back(solve_row(32'sh1000_0000, 1'b0, 1'b0, 0));
    plan.push_back(solve_row(32'sh7FFF_FFFF, 1'b0, 1'b0, 0));
    plan.push_back(solve_row(32'sh8000_0000, 1'b0, 1'b0, 0));
    plan.push_back(write_row(REG_MAXIT, 32'd2047));
    plan.push_back(write_row(REG_TOL, 32'd0));
    plan.push_back(solve_row(32'sh0000_0001, 1'b0, 1'b0, 0));
    plan.push_back(solve_row(-32'sh3243_F6A9, 1'b0, 1'b0, 0));
    // Widest tolerance and a limit of one step.
    plan.push_back(write_row(REG_TOL, 32'd65535));
    plan.push_back(write_row(REG_MAXIT, 32'd1));
    plan.push_back(write_row(REG_ECC, 32'h8000_0000));
    plan.push_back(solve_row(32'sh2000_0000, 1'b0, 1'b0, 0));
    plan.push_back(solve_row(-32'sh2000_0000, 1'b0, 1'b0, 0));
    plan.push_back(write_row(REG_MAXIT, 32'd30));
    plan.push_back(write_row(REG_TOL, 32'd1));
    plan.push_back(solve_row(32'sh6487_ED51, 1'b0, 1'b0, 0));
    plan.push_back(solve_row(32'sh5555_5555, 1'b0, 1'b0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].reg_value);
      end else begin
        offer_anomaly(plan[i].mean, plan[i].typed, plan[i].want);
      end
    end

    // Random part: twelve phases of a hundred items (four when the limit exceeds 200),
    // each with a fresh register setting. The idle pattern changes every four phases.
    for (int phase = 0; phase < 12; phase++) begin
      mode = phase / 4;
      settle();
      src_idle = (mode == 0) ? 21 : (mode == 1) ? 60 : 0;
      snk_idle = (mode == 0) ? 60 : (mode == 1) ? 21 : 0;
      pick = $urandom_range(9);
      write_reg(REG_ECC, pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF :
                         pick < 5 ? $urandom_range(32'hF000_0000) : $urandom);
      // Long limits are kept to short phases so the run stays bounded.
      pick = $urandom_range(9);
      write_reg(REG_MAXIT, pick == 0 ? 32'd1 : pick == 1 ? 32'd2047 :
                           32'($urandom_range(40, 2)));
      pick = $urandom_range(9);
      write_reg(REG_TOL, pick == 0 ? 32'd0 : pick == 1 ? 32'd65535 :
                         pick < 7 ? 32'($urandom_range(16)) : 32'($urandom_range(65535)));
      count = (maxit_shadow > 200) ? 4 : 100;
      for (int n = 0; n < count; n++) begin
        pick = $urandom_range(9);
        mean = pick < 5 ? angle_t'($urandom) :
               pick < 9 ? angle_t'($signed($urandom_range(32'h6487_ED51)) -
                                   32'sh3243_F6A8) :
               (pick[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000);
        offer_anomaly(mean, 1'b0, none);
      end
    end

    settle();
    $display("Covered %0d mean anomalies, %0d results checked, %0d stopped at the limit.",
             solved, checked, unconverged);
    $display("Register settings spanned zero to near-unit eccentricity and limits 0 to 2047.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
